FILE: rtl/core/dltq_pkg.sv
package dltq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MEM_DEPTH  = 1 << IDX_W;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int ID_W       = 4;
    localparam int DELAY_W    = 32;
    localparam int CMD_W      = 2;
    localparam int EVT_W      = 3;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ID_W-1:0]    t_id;
    typedef logic [DELAY_W-1:0] t_delay;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [EVT_W-1:0] {
        EV_STARTED = 3'd0,
        EV_REFUSED = 3'd1,
        EV_STOPPED = 3'd2,
        EV_NOT_RUN = 3'd3,
        EV_EXPIRED = 3'd4
    } t_evt;

    // one list slot: delay relative to the slot before it, and its timer
    typedef struct packed {
        t_delay delta;
        t_idx   owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_entry wdata;
        t_idx   raddr;
    } t_lst_req;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_delay wdata;
        t_idx   raddr;
    } t_per_req;

    typedef struct packed {
        logic valid;
        t_evt evt;
        t_id  id;
        logic last;
    } t_emit;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_REM,
        S_REPLY,
        S_TICK_RD,
        S_TICK_CHK,
        S_POP,
        S_PER,
        S_TICK_END
    } t_state;

endpackage

FILE: rtl/core/dltq_if.sv
interface dltq_cmd_if;
    import dltq_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay;
    logic               periodic;

    modport source (output valid, command, timer_id, delay, periodic, input ready);
    modport sink   (input valid, command, timer_id, delay, periodic, output ready);
endinterface

interface dltq_evt_if;
    import dltq_pkg::*;

    logic             valid;
    logic             ready;
    logic [EVT_W-1:0] event_res;
    logic [ID_W-1:0]  which_timer;
    logic             last;

    modport source (output valid, event_res, which_timer, last, input ready);
    modport sink   (input valid, event_res, which_timer, last, output ready);
endinterface

FILE: rtl/core/dltq_ram.sv
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/dltq_ctrl.sv
module dltq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dltq_cmd_if.sink           i_cmd,
    input  logic               i_emit_ok,
    output dltq_pkg::t_emit    o_emit,
    output dltq_pkg::t_lst_req o_lst,
    input  dltq_pkg::t_entry   i_lst_rdata,
    output dltq_pkg::t_per_req o_per,
    input  dltq_pkg::t_delay   i_per_rdata
);
    import dltq_pkg::*;

    t_state                r_state, n_state;
    t_idx                  r_head, n_head;
    t_cnt                  r_count, n_count;
    t_cnt                  r_k, n_k;
    logic [NUM_TIMERS-1:0] r_running, n_running;
    logic [NUM_TIMERS-1:0] r_repeat, n_repeat;
    logic                  r_pend_valid, n_pend_valid;
    t_id                   r_pend_id, n_pend_id;
    t_id                   r_id, n_id;
    t_delay                r_d, n_d;
    t_evt                  r_code, n_code;
    logic                  r_tick, n_tick;
    logic                  r_found, n_found;
    logic                  r_first, n_first;
    t_entry                r_carry, n_carry;

    t_entry cur;
    t_idx   in_idx;
    t_idx   id_idx;
    t_idx   k_addr;
    logic   acc;
    logic   id_ok;
    logic   k_lt;
    logic   due;
    logic   can_emit;

    assign cur         = i_lst_rdata;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign in_idx      = IDX_W'(i_cmd.timer_id);
    assign id_ok       = int'(i_cmd.timer_id) < NUM_TIMERS;
    assign id_idx      = IDX_W'(r_id);
    assign k_lt        = r_k < r_count;
    assign k_addr      = r_head + IDX_W'(r_k);
    // first look at the head in a tick sees the value before the decrement
    assign due         = r_first ? (cur.delta <= t_delay'(1)) : (cur.delta == '0);
    assign can_emit    = !r_pend_valid || i_emit_ok;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_cmd.command)
                        CMD_START: n_state = (id_ok && !r_running[in_idx]) ? S_INS : S_REPLY;
                        CMD_STOP:  n_state = (id_ok && r_running[in_idx]) ? S_REM : S_REPLY;
                        CMD_TICK:  n_state = S_TICK_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (!k_lt) begin
                    n_state = r_tick ? S_TICK_RD : S_REPLY;
                end
            end
            S_REM: begin
                if (!k_lt) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (i_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_RD:  n_state = (r_count == '0) ? S_TICK_END : S_TICK_CHK;
            S_TICK_CHK: n_state = due ? S_POP : S_TICK_END;
            S_POP: begin
                if (can_emit) begin
                    n_state = r_repeat[id_idx] ? S_PER : S_TICK_RD;
                end
            end
            S_PER: n_state = S_INS;
            S_TICK_END: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_k          = '0;
        n_running    = r_running;
        n_repeat     = r_repeat;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_id         = r_id;
        n_d          = r_d;
        n_code       = r_code;
        n_tick       = r_tick;
        n_found      = r_found;
        n_first      = r_first;
        n_carry      = r_carry;
        o_emit       = '0;
        o_lst.we     = 1'b0;
        o_lst.waddr  = k_addr;
        o_lst.wdata  = r_carry;
        o_per.we     = 1'b0;
        o_per.waddr  = in_idx;
        o_per.wdata  = i_cmd.delay;
        o_per.raddr  = id_idx;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_id    = i_cmd.timer_id;
                    n_d     = i_cmd.delay;
                    n_tick  = (i_cmd.command == CMD_TICK);
                    n_found = 1'b0;
                    n_first = 1'b1;
                    case (i_cmd.command)
                        CMD_START: begin
                            if (id_ok && !r_running[in_idx]) begin
                                o_per.we          = 1'b1;
                                n_running[in_idx] = 1'b1;
                                n_repeat[in_idx]  = i_cmd.periodic;
                                n_code            = EV_STARTED;
                            end else begin
                                n_code = EV_REFUSED;
                            end
                        end
                        CMD_STOP: begin
                            if (id_ok && r_running[in_idx]) begin
                                n_running[in_idx] = 1'b0;
                                n_repeat[in_idx]  = 1'b0;
                                n_code            = EV_STOPPED;
                            end else begin
                                n_code = EV_NOT_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                // walk to the slot, then ripple the tail up one slot a cycle
                n_k = r_k + t_cnt'(1);
                if (!r_found) begin
                    if (k_lt && r_d >= cur.delta) begin
                        n_d = r_d - cur.delta;
                    end else begin
                        o_lst.we          = 1'b1;
                        o_lst.wdata.delta = r_d;
                        o_lst.wdata.owner = id_idx;
                        n_found           = 1'b1;
                        n_carry.delta     = cur.delta - r_d;
                        n_carry.owner     = cur.owner;
                    end
                end else begin
                    o_lst.we = 1'b1;
                    n_carry  = cur;
                end
                if (!k_lt) begin
                    n_count = r_count + t_cnt'(1);
                end
            end
            S_REM: begin
                // the removed delta folds into its successor, the rest slide down
                n_k = r_k + t_cnt'(1);
                if (!r_found) begin
                    if (k_lt && cur.owner == id_idx) begin
                        n_found       = 1'b1;
                        n_carry.delta = cur.delta;
                    end
                end else if (k_lt) begin
                    o_lst.we          = 1'b1;
                    o_lst.waddr       = k_addr - t_idx'(1);
                    o_lst.wdata.delta = cur.delta + r_carry.delta;
                    o_lst.wdata.owner = cur.owner;
                    n_carry.delta     = '0;
                end
                if (!k_lt) begin
                    n_count = r_count - t_cnt'(1);
                end
            end
            S_REPLY: begin
                if (i_emit_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.evt   = r_code;
                    o_emit.id    = r_id;
                    o_emit.last  = 1'b1;
                end
            end
            S_TICK_RD: ;
            S_TICK_CHK: begin
                n_first = 1'b0;
                if (r_first && cur.delta != '0) begin
                    o_lst.we          = 1'b1;
                    o_lst.waddr       = r_head;
                    o_lst.wdata.delta = cur.delta - t_delay'(1);
                    o_lst.wdata.owner = cur.owner;
                end
                if (due) begin
                    n_id = ID_W'(cur.owner);
                end
            end
            S_POP: begin
                // an expiry is held back until we know whether another follows
                if (can_emit) begin
                    if (r_pend_valid) begin
                        o_emit.valid = 1'b1;
                        o_emit.evt   = EV_EXPIRED;
                        o_emit.id    = r_pend_id;
                        o_emit.last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = r_id;
                    n_head       = r_head + t_idx'(1);
                    n_count      = r_count - t_cnt'(1);
                    if (r_repeat[id_idx]) begin
                        n_found = 1'b0;
                    end else begin
                        n_running[id_idx] = 1'b0;
                    end
                end
            end
            S_PER: begin
                n_d = (i_per_rdata == '0) ? t_delay'(1) : i_per_rdata;
            end
            S_TICK_END: begin
                if (can_emit && r_pend_valid) begin
                    o_emit.valid = 1'b1;
                    o_emit.evt   = EV_EXPIRED;
                    o_emit.id    = r_pend_id;
                    o_emit.last  = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: ;
        endcase

        o_lst.raddr = r_head + IDX_W'(n_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_running    <= '0;
            r_repeat     <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_running    <= n_running;
            r_repeat     <= n_repeat;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_pend_id <= n_pend_id;
        r_id      <= n_id;
        r_d       <= n_d;
        r_code    <= n_code;
        r_tick    <= n_tick;
        r_found   <= n_found;
        r_first   <= n_first;
        r_carry   <= n_carry;
    end

endmodule

FILE: rtl/core/delta_list_timer_queue_unit.sv
// Start/stop: one result; the list walk through the entry RAM handles one slot a cycle.
// Tick: decrements the head delta, pops each expired entry, and re-inserts each periodic
//   timer with its period through the list walk.
// One command is in work at a time; the output register lets the next command in while
//   the final result still waits. Synchronous active-low reset empties the list and
//   clears the running, periodic and pending flags; the entry and period RAMs are not cleared.
module delta_list_timer_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dltq_cmd_if.sink    i_cmd,
    dltq_evt_if.source  o_evt
);
    import dltq_pkg::*;

    t_emit    emit;
    t_lst_req lst_req;
    t_entry   lst_rdata;
    t_per_req per_req;
    t_delay   per_rdata;
    logic     emit_ok;

    logic     r_out_valid;
    t_evt     r_out_evt;
    t_id      r_out_id;
    logic     r_out_last;

    dltq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_lst_ram (
        .i_clk   (i_clk),
        .i_we    (lst_req.we),
        .i_waddr (lst_req.waddr),
        .i_wdata (lst_req.wdata),
        .i_raddr (lst_req.raddr),
        .o_rdata (lst_rdata)
    );

    dltq_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (MEM_DEPTH)
    ) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_req.we),
        .i_waddr (per_req.waddr),
        .i_wdata (per_req.wdata),
        .i_raddr (per_req.raddr),
        .o_rdata (per_rdata)
    );

    dltq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_emit_ok   (emit_ok),
        .o_emit      (emit),
        .o_lst       (lst_req),
        .i_lst_rdata (lst_rdata),
        .o_per       (per_req),
        .i_per_rdata (per_rdata)
    );

    assign emit_ok = !r_out_valid || o_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_evt  <= emit.evt;
            r_out_id   <= emit.id;
            r_out_last <= emit.last;
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_res   = r_out_evt;
    assign o_evt.which_timer = r_out_id;
    assign o_evt.last        = r_out_last;

endmodule

FILE: rtl/core/dltq_chk.sv
module dltq_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic [dltq_pkg::CMD_W-1:0] i_in_command,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [dltq_pkg::EVT_W-1:0] i_out_event,
    input logic [dltq_pkg::ID_W-1:0]  i_out_timer,
    input logic                     i_out_last
);
    import dltq_pkg::*;

    // a stalled result beat must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_event) && $stable(i_out_timer)
             && $stable(i_out_last)))
        else $error("result beat changed while stalled");

    // any real command keeps the block busy for at least the following cycle
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready &&
         (i_in_command == CMD_START || i_in_command == CMD_STOP ||
          i_in_command == CMD_TICK)) |=> !i_in_ready)
        else $error("command taken while previous one still in work");

    // start and stop answer with exactly one beat
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_event != EV_EXPIRED) |-> i_out_last)
        else $error("start/stop reply without last");

    // nothing is accepted while an expiry burst is still being delivered
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_event == EV_EXPIRED && !i_out_last) |-> !i_in_ready)
        else $error("command accepted in the middle of an expiry burst");

endmodule

bind delta_list_timer_queue_unit dltq_chk u_dltq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_in_command (i_cmd.command),
    .i_out_valid  (o_evt.valid),
    .i_out_ready  (o_evt.ready),
    .i_out_event  (o_evt.event_res),
    .i_out_timer  (o_evt.which_timer),
    .i_out_last   (o_evt.last)
);
